/* sv/tcpq_pkg.sv */
// Shared types, codes and constants of the two-class priority queue.
// Used by every module of the block but tcpq_ram; no dependencies of its own.
`default_nettype none

package tcpq_pkg;

  localparam int TAG_W            = 16;
  localparam int MODE_W           = 3;
  localparam int STATUS_W         = 2;
  localparam int OUT_DATA_W       = 24;
  localparam int MAX_RESULTS      = 32;
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int HISTORY_DEPTH_DEF = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ_NORMAL = 3'd0,
    MODE_ENQ_URGENT = 3'd1,
    MODE_SERVE      = 3'd2,
    MODE_PEEK       = 3'd3,
    MODE_DUMP       = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_SERVE,
    S_EMPTY,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // request accepted: latch it, set up history walk
    logic enq;        // perform enqueue and post result
    logic serve;      // perform serve or peek and post result
    logic empty;      // post an empty result
    logic dump_emit;  // post one history entry and step the walk
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic urg_empty;
    logic norm_empty;
    logic hist_empty;
    logic dump_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* sv/two_class_priority_queue_with_history_core.sv */
// Two-class strict-priority tag queue with a history of served tags.
// Input channel s_*: s_tuser = mode, s_tdata = entry tag. One request at a time.
// Output channel m_*: m_tdata = status and result tag, m_tuser = from urgent,
// m_tlast = last result of the request.
// Enqueue, serve and peek: one result, formed in the state after acceptance and
// registered in the result register; the next request is accepted once that
// result has been loaded.
// Serve and peek take the urgent FIFO first; serve pushes the tag onto the
// history, overwriting the oldest entry once the history is full.
// Dump: the history newest first, up to 32 results; each entry passes S_DUMP_RD
// then S_DUMP_OUT, for the registered read port of the history RAM (address, then data).
// A dump of an empty history, or serve/peek with both FIFOs empty, gives one
// result with status empty. Modes 5 to 7 are accepted and dropped.
// The result register lets a request be accepted while the previous result
// still waits; when the receiver stalls, the block holds the pending result
// and stops before posting the next one.
// Reset (rst, synchronous) clears heads, counts, the history pointer and the
// output valid; the tag RAMs are not cleared and need no clearing pass.
// Depends on tcpq_pkg, tcpq_ctrl, tcpq_dp, tcpq_ram.
`default_nettype none

module two_class_priority_queue_with_history_core #(
  parameter int QUEUE_DEPTH   = tcpq_pkg::QUEUE_DEPTH_DEF,
  parameter int HISTORY_DEPTH = tcpq_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [tcpq_pkg::TAG_W-1:0]      s_tdata,   // [15:0] entry_tag
  input  wire logic [tcpq_pkg::MODE_W-1:0]     s_tuser,   // [2:0] mode
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [tcpq_pkg::OUT_DATA_W-1:0] m_tdata,   // [1:0] status, [17:2] result_tag
  output logic                                 m_tuser,   // [0] from_urgent
  output logic                                 m_tlast    // last_of_run
);

  import tcpq_pkg::*;

  ctrl_cmd_t        cmd;
  dp_stat_t         stat;
  status_t          out_status;
  logic [TAG_W-1:0] out_tag;

  tcpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .mode     (mode_t'(s_tuser)),
    .stat     (stat),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  tcpq_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_mode    (mode_t'(s_tuser)),
    .in_tag     (s_tdata),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .out_status (out_status),
    .out_tag    (out_tag),
    .out_urgent (m_tuser),
    .out_last   (m_tlast)
  );

  assign m_tdata = {(OUT_DATA_W - TAG_W - STATUS_W)'(0), out_tag, out_status};

endmodule

`default_nettype wire

/* sv/tcpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* sv/tcpq_ctrl.sv */
// Controller state machine of the two-class priority queue.
// Depends on tcpq_pkg; drives the datapath through ctrl_cmd_t.
`default_nettype none

module tcpq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  input  wire tcpq_pkg::mode_t      mode,
  input  wire tcpq_pkg::dp_stat_t   stat,
  output logic                      s_tready,
  output tcpq_pkg::ctrl_cmd_t       cmd
);

  import tcpq_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (mode) inside
            MODE_ENQ_NORMAL, MODE_ENQ_URGENT: state_next = S_ENQ;
            MODE_SERVE, MODE_PEEK: begin
              state_next = (stat.urg_empty && stat.norm_empty) ? S_EMPTY : S_SERVE;
            end
            MODE_DUMP: state_next = stat.hist_empty ? S_EMPTY : S_DUMP_RD;
            default:   state_next = S_IDLE;  // meaningless mode: drop it
          endcase
        end
      end
      S_ENQ, S_SERVE, S_EMPTY: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DUMP_RD: state_next = S_DUMP_OUT;
      S_DUMP_OUT: begin
        if (stat.out_free) begin
          state_next = stat.dump_last ? S_IDLE : S_DUMP_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = (state == S_IDLE);
    cmd           = '0;
    cmd.load      = accept;
    cmd.enq       = (state == S_ENQ)      && stat.out_free;
    cmd.serve     = (state == S_SERVE)    && stat.out_free;
    cmd.empty     = (state == S_EMPTY)    && stat.out_free;
    cmd.dump_emit = (state == S_DUMP_OUT) && stat.out_free;
  end

endmodule

`default_nettype wire

/* sv/tcpq_dp.sv */
// Datapath: the two tag FIFOs, the history stack and the result register.
// Depends on tcpq_pkg and tcpq_ram; steered by tcpq_ctrl.
`default_nettype none

module tcpq_dp #(
  parameter int QUEUE_DEPTH   = tcpq_pkg::QUEUE_DEPTH_DEF,
  parameter int HISTORY_DEPTH = tcpq_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tcpq_pkg::ctrl_cmd_t        cmd,
  output tcpq_pkg::dp_stat_t              stat,
  input  wire tcpq_pkg::mode_t            in_mode,
  input  wire logic [tcpq_pkg::TAG_W-1:0] in_tag,
  input  wire logic                       m_tready,
  output logic                            m_tvalid,
  output tcpq_pkg::status_t               out_status,
  output logic      [tcpq_pkg::TAG_W-1:0] out_tag,
  output logic                            out_urgent,
  output logic                            out_last
);

  import tcpq_pkg::*;

  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int HW  = $clog2(HISTORY_DEPTH);
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);
  localparam int RW  = $clog2(MAX_RESULTS + 1);

  // latched request
  mode_t            req_mode;
  logic [TAG_W-1:0] req_tag;

  // queue state
  logic [QW-1:0]  norm_head, urg_head;
  logic [QCW-1:0] norm_count, urg_count;
  logic [TAG_W-1:0] norm_rd, urg_rd;

  // history state
  logic [HW-1:0]  hist_top;
  logic [HCW-1:0] hist_count;
  logic [HW-1:0]  walk;
  logic [RW-1:0]  remain;
  logic [TAG_W-1:0] hist_rd;

  // enqueue side
  logic           enq_urgent;
  logic [QW-1:0]  sel_head;
  logic [QCW-1:0] sel_count;
  logic           sel_full;
  logic [QW:0]    wr_sum;
  logic [QW-1:0]  wr_pos;
  logic           norm_wr, urg_wr;

  // serve side
  logic           take_urgent;
  logic           do_pop;
  logic [TAG_W-1:0] front_tag;

  logic           load_out;
  status_t        res_status;
  logic [TAG_W-1:0] res_tag;
  logic           res_urgent, res_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode <= in_mode;
      req_tag  <= in_tag;
    end
  end

  // FIFO write slot: head plus count, wrapped once (count is below depth)
  always_comb begin
    enq_urgent = (req_mode == MODE_ENQ_URGENT);
    sel_head   = enq_urgent ? urg_head  : norm_head;
    sel_count  = enq_urgent ? urg_count : norm_count;
    sel_full   = (sel_count == QCW'(QUEUE_DEPTH));
    wr_sum     = {1'b0, sel_head} + (QW + 1)'(sel_count);
    wr_pos     = (wr_sum >= (QW + 1)'(QUEUE_DEPTH)) ?
                 QW'(wr_sum - (QW + 1)'(QUEUE_DEPTH)) : wr_sum[QW-1:0];
    norm_wr    = cmd.enq && !sel_full && !enq_urgent;
    urg_wr     = cmd.enq && !sel_full && enq_urgent;
  end

  always_comb begin
    take_urgent = (urg_count != '0);
    front_tag   = take_urgent ? urg_rd : norm_rd;
    do_pop      = cmd.serve && (req_mode == MODE_SERVE);
  end

  tcpq_ram #(.WIDTH(TAG_W), .DEPTH(QUEUE_DEPTH)) u_norm_ram (
    .clk     (clk),
    .wr_en   (norm_wr),
    .wr_addr (wr_pos),
    .wr_data (req_tag),
    .rd_addr (norm_head),
    .rd_data (norm_rd)
  );

  tcpq_ram #(.WIDTH(TAG_W), .DEPTH(QUEUE_DEPTH)) u_urg_ram (
    .clk     (clk),
    .wr_en   (urg_wr),
    .wr_addr (wr_pos),
    .wr_data (req_tag),
    .rd_addr (urg_head),
    .rd_data (urg_rd)
  );

  tcpq_ram #(.WIDTH(TAG_W), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
    .clk     (clk),
    .wr_en   (do_pop),
    .wr_addr (hist_top),
    .wr_data (front_tag),
    .rd_addr (walk),
    .rd_data (hist_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_head  <= '0;
      norm_count <= '0;
      urg_head   <= '0;
      urg_count  <= '0;
    end else begin
      if (norm_wr) begin
        norm_count <= norm_count + QCW'(1);
      end
      if (urg_wr) begin
        urg_count <= urg_count + QCW'(1);
      end
      if (do_pop && take_urgent) begin
        urg_head  <= (urg_head == QW'(QUEUE_DEPTH - 1)) ? '0 : urg_head + QW'(1);
        urg_count <= urg_count - QCW'(1);
      end
      if (do_pop && !take_urgent) begin
        norm_head  <= (norm_head == QW'(QUEUE_DEPTH - 1)) ? '0 : norm_head + QW'(1);
        norm_count <= norm_count - QCW'(1);
      end
    end
  end

  // history push overwrites the oldest entry once full
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_top   <= '0;
      hist_count <= '0;
    end else if (do_pop) begin
      hist_top <= (hist_top == HW'(HISTORY_DEPTH - 1)) ? '0 : hist_top + HW'(1);
      if (hist_count != HCW'(HISTORY_DEPTH)) begin
        hist_count <= hist_count + HCW'(1);
      end
    end
  end

  // dump walk: newest first, capped at the result limit
  always_ff @(posedge clk) begin
    if (rst) begin
      walk   <= '0;
      remain <= '0;
    end else if (cmd.load) begin
      walk <= (hist_top == '0) ? HW'(HISTORY_DEPTH - 1) : hist_top - HW'(1);
      if (32'(hist_count) > 32'(MAX_RESULTS)) begin
        remain <= RW'(MAX_RESULTS);
      end else begin
        remain <= RW'(hist_count);
      end
    end else if (cmd.dump_emit) begin
      walk   <= (walk == '0) ? HW'(HISTORY_DEPTH - 1) : walk - HW'(1);
      remain <= remain - RW'(1);
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_tag    = '0;
    res_urgent = 1'b0;
    res_last   = 1'b1;
    if (cmd.enq) begin
      res_status = sel_full ? ST_FULL : ST_OK;
    end else if (cmd.serve) begin
      res_tag    = front_tag;
      res_urgent = take_urgent;
    end else if (cmd.empty) begin
      res_status = ST_EMPTY;
    end else if (cmd.dump_emit) begin
      res_tag  = hist_rd;
      res_last = (remain == RW'(1));
    end
  end

  assign load_out = cmd.enq || cmd.serve || cmd.empty || cmd.dump_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_tag    <= res_tag;
      out_urgent <= res_urgent;
      out_last   <= res_last;
    end
  end

  always_comb begin
    stat.urg_empty  = (urg_count == '0);
    stat.norm_empty = (norm_count == '0);
    stat.hist_empty = (hist_count == '0);
    stat.dump_last  = (remain == RW'(1));
    stat.out_free   = !m_tvalid || m_tready;
  end

endmodule

`default_nettype wire

/* sv/tcpq_checker.sv */
// Port-level checks on the two-class priority queue, bound to its top level.
// Depends on tcpq_pkg.
`default_nettype none

module tcpq_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic [tcpq_pkg::MODE_W-1:0]     s_tuser,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [tcpq_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic                            m_tuser,
  input wire logic                            m_tlast
);

  import tcpq_pkg::*;

  // nothing posted straight out of reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

  // full or empty results carry no tag and close the request
  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == ST_FULL || m_tdata[1:0] == ST_EMPTY)
      |-> m_tdata[17:2] == '0 && !m_tuser && m_tlast)
    else $error("failure result with payload");

  // an urgent-origin result is a single ok serve or peek result
  a_urgent_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[1:0] == ST_OK && m_tlast)
    else $error("urgent flag on wrong result");

  // a meaningful request occupies the block for at least the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == MODE_ENQ_NORMAL || s_tuser == MODE_ENQ_URGENT
      || s_tuser == MODE_SERVE || s_tuser == MODE_PEEK || s_tuser == MODE_DUMP)
      |=> !s_tready)
    else $error("request accepted while busy");

endmodule

bind two_class_priority_queue_with_history_core tcpq_checker u_tcpq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/two_class_priority_queue_with_history_core_tb.sv */
// Self-checking testbench for two_class_priority_queue_with_history_core.
// Uses tcpq_pkg. Mirrors the two FIFOs and the service history in a local model
// and checks each result against it under random stalls on both channels.
`default_nettype none

module two_class_priority_queue_with_history_core_tb;
  import tcpq_pkg::*;

  localparam int QDEPTH     = QUEUE_DEPTH_DEF;
  localparam int HDEPTH     = HISTORY_DEPTH_DEF;
  localparam int CYCLE_CAP  = 200000;
  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct {
    status_t     status;
    logic [15:0] tag;
    logic        urgent;
    logic        last;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TAG_W-1:0]      s_tdata = '0;   // [15:0] entry_tag
  logic [MODE_W-1:0]     s_tuser = '0;   // [2:0] mode
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_tdata;        // [1:0] status, [17:2] result_tag
  logic                  m_tuser;        // [0] from_urgent
  logic                  m_tlast;

  // local copy of the block's state
  logic [15:0] normal_tags[$];
  logic [15:0] urgent_tags[$];
  logic [15:0] served_log[HDEPTH];
  int          hist_top   = 0;
  int          hist_count = 0;

  outcome_t outcome_q[$];
  int       mismatches  = 0;
  int       cycle_count = 0;
  int       stall_left  = 0;
  bit       idle_on     = 1'b1;
  bit       calm        = 1'b0;

  two_class_priority_queue_with_history_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("FAIL two_class_priority_queue_with_history_core");
      $finish;
    end
  end

  // receiver: stall in bursts of random length
  always @(posedge clk) begin
    if (rst || calm) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic log_mismatch(input string field, input logic [31:0] got,
                              input logic [31:0] want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %0h, want %0h", cycle_count, field, got, want);
  endtask

  function automatic void add_outcome(input status_t st, input logic [15:0] tag,
                                      input logic urg, input logic last);
    outcome_t o;
    o.status = st;
    o.tag    = tag;
    o.urgent = urg;
    o.last   = last;
    outcome_q.push_back(o);
  endfunction

  task automatic predict_outcome(input logic [MODE_W-1:0] mode, input logic [15:0] tag);
    logic [15:0] head_tag;
    logic        from_urg;
    bit          found;
    int          n;
    found = 1'b1;
    from_urg = 1'b0;
    head_tag = '0;
    case (mode)
      MODE_ENQ_NORMAL: begin
        if (normal_tags.size() < QDEPTH) begin
          normal_tags.push_back(tag);
          add_outcome(ST_OK, '0, 1'b0, 1'b1);
        end else begin
          add_outcome(ST_FULL, '0, 1'b0, 1'b1);
        end
      end
      MODE_ENQ_URGENT: begin
        if (urgent_tags.size() < QDEPTH) begin
          urgent_tags.push_back(tag);
          add_outcome(ST_OK, '0, 1'b0, 1'b1);
        end else begin
          add_outcome(ST_FULL, '0, 1'b0, 1'b1);
        end
      end
      MODE_SERVE, MODE_PEEK: begin
        if (urgent_tags.size() != 0) begin
          head_tag = urgent_tags[0];
          from_urg = 1'b1;
          if (mode == MODE_SERVE) void'(urgent_tags.pop_front());
        end else if (normal_tags.size() != 0) begin
          head_tag = normal_tags[0];
          if (mode == MODE_SERVE) void'(normal_tags.pop_front());
        end else begin
          found = 1'b0;
        end
        if (!found) begin
          add_outcome(ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          // push the served tag, overwriting the oldest once full
          if (mode == MODE_SERVE) begin
            served_log[hist_top] = head_tag;
            hist_top = (hist_top + 1) % HDEPTH;
            if (hist_count < HDEPTH) hist_count++;
          end
          add_outcome(ST_OK, head_tag, from_urg, 1'b1);
        end
      end
      MODE_DUMP: begin
        if (hist_count == 0) begin
          add_outcome(ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          n = (hist_count > MAX_RESULTS) ? MAX_RESULTS : hist_count;
          for (int k = 0; k < n; k++)
            add_outcome(ST_OK, served_log[(hist_top + HDEPTH - 1 - k) % HDEPTH], 1'b0,
                        k == n - 1);
        end
      end
      default: ;  // spare modes are dropped
    endcase
  endtask

  // hold valid high across back-to-back requests; drop it only for a gap
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [15:0] tag);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= tag;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_outcome(mode, tag);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_tag();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(input bit fill_bias);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      case ($urandom_range(0, 2))
        0: return MODE_SPARE_5;
        1: return MODE_SPARE_6;
        default: return MODE_SPARE_7;
      endcase
    end
    if (fill_bias) begin
      if (r < 40) return MODE_ENQ_NORMAL;
      if (r < 70) return MODE_ENQ_URGENT;
      if (r < 85) return MODE_SERVE;
      if (r < 93) return MODE_PEEK;
      return MODE_DUMP;
    end
    if (r < 20) return MODE_ENQ_NORMAL;
    if (r < 30) return MODE_ENQ_URGENT;
    if (r < 70) return MODE_SERVE;
    if (r < 85) return MODE_PEEK;
    return MODE_DUMP;
  endfunction

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (outcome_q.size() == 0) begin
        log_mismatch("unexpected result, tdata", 32'(m_tdata), '0);
      end else begin
        want = outcome_q.pop_front();
        if (m_tdata[1:0] !== want.status)
          log_mismatch("status", 32'(m_tdata[1:0]), 32'(want.status));
        if (m_tdata[17:2] !== want.tag)
          log_mismatch("result_tag", 32'(m_tdata[17:2]), 32'(want.tag));
        if (m_tdata[23:18] !== '0)
          log_mismatch("tdata padding", 32'(m_tdata[23:18]), '0);
        if (m_tuser !== want.urgent)
          log_mismatch("from_urgent", 32'(m_tuser), 32'(want.urgent));
        if (m_tlast !== want.last)
          log_mismatch("last_of_run", 32'(m_tlast), 32'(want.last));
      end
    end
  end

  // empty block: serve, peek and dump with nothing stored, spare modes
  task automatic test_empty_block();
    send_request(MODE_PEEK, 16'hFFFF);
    send_request(MODE_SERVE, 16'h0000);
    send_request(MODE_DUMP, 16'hFFFF);
    send_request(MODE_SPARE_5, 16'hFFFF);
    send_request(MODE_SPARE_6, 16'h0000);
    send_request(MODE_SPARE_7, 16'h1234);
  endtask

  // each of the five defined modes, urgent ahead of normal, tag extremes
  task automatic test_basic_ops();
    send_request(MODE_ENQ_NORMAL, 16'h0000);
    send_request(MODE_ENQ_NORMAL, 16'hFFFF);
    send_request(MODE_ENQ_URGENT, 16'hA5A5);
    send_request(MODE_ENQ_URGENT, 16'h5A5A);
    send_request(MODE_PEEK, 16'h0000);
    send_request(MODE_SERVE, 16'h0000);
    send_request(MODE_SERVE, 16'h0000);
    send_request(MODE_PEEK, 16'h0000);
    send_request(MODE_SERVE, 16'h0000);
    send_request(MODE_SERVE, 16'h0000);
    send_request(MODE_SERVE, 16'h0000);
    send_request(MODE_DUMP, 16'h0000);
  endtask

  // fill both FIFOs past full, drain them and wrap the history
  task automatic test_fill_and_wrap();
    for (int i = 0; i <= QDEPTH; i++) send_request(MODE_ENQ_NORMAL, pick_tag());
    for (int i = 0; i <= QDEPTH; i++) send_request(MODE_ENQ_URGENT, pick_tag());
    wait_drained();
    for (int i = 0; i <= 2 * QDEPTH; i++) send_request(MODE_SERVE, pick_tag());
    send_request(MODE_DUMP, pick_tag());
    wait_drained();
  endtask

  // random mix in blocks that alternate between filling and draining
  task automatic test_random_mix();
    bit fill_bias;
    fill_bias = 1'b1;
    for (int blk = 0; blk < 4; blk++) begin
      idle_on = (blk != 2);
      for (int i = 0; i < 4; i++) send_request(pick_mode(fill_bias), pick_tag());
      fill_bias = ~fill_bias;
    end
    idle_on = 1'b1;
  endtask

  // closing stretch with no idling on either side
  task automatic test_quiet_tail();
    calm    = 1'b1;
    idle_on = 1'b0;
    for (int i = 0; i < 4; i++) send_request(pick_mode(1'b0), pick_tag());
    send_request(MODE_DUMP, pick_tag());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_block();
    test_basic_ops();
    test_fill_and_wrap();
    test_random_mix();
    test_quiet_tail();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS two_class_priority_queue_with_history_core");
    end else begin
      $display("FAIL two_class_priority_queue_with_history_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
